[hdl/bfr_pkg.sv]
// Shared types and constants for the brace fold range finder.
// No dependencies; imported by every module of the block and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package bfr_pkg;

  localparam int CHAR_W    = 8;
  localparam int OUT_W     = 20;
  localparam int DEPTH_W   = 16;
  localparam int MAXR_W    = 13;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [MAXR_W-1:0]  MAXR_RESET = 13'd512;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX  = 16'hFFFF;

  localparam logic [CHAR_W-1:0] CH_OPEN    = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_CLOSE   = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

  // Register index, taken from paddr[2].
  localparam logic REG_MAX_RANGES = 1'b0;

  // Stack shift command, common to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } bfr_shift_t;

  // One result; start_line lands in the low bits of tdata.
  typedef struct packed {
    logic [OUT_W-1:0] end_line;
    logic [OUT_W-1:0] start_line;
  } bfr_range_t;

  localparam int RANGE_W = $bits(bfr_range_t);

endpackage

`default_nettype wire

[hdl/bfr_cell.sv]
// One entry of the shifting brace stack.
// Depends on bfr_pkg (shift command type).
`timescale 1ns / 1ps
`default_nettype none

module bfr_cell
  import bfr_pkg::*;
#(
  parameter int LINE_WIDTH = 20
) (
  input  wire logic                  clk,
  input  wire bfr_shift_t            shift,
  input  wire logic [LINE_WIDTH-1:0] from_above,
  input  wire logic [LINE_WIDTH-1:0] from_below,
  output logic      [LINE_WIDTH-1:0] entry
);

  // Push moves every entry one place deeper, pop one place up.
  always_ff @(posedge clk) begin
    if (shift.push) begin
      entry <= from_above;
    end else if (shift.pop) begin
      entry <= from_below;
    end
  end

endmodule

`default_nettype wire

[hdl/bfr_out_buf.sv]
// Output register plus skid stage for the result stream.
// Depends on bfr_pkg (result type).
`timescale 1ns / 1ps
`default_nettype none

module bfr_out_buf
  import bfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       res_valid,
  input  wire bfr_range_t res_data,
  output logic            room,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output bfr_range_t      m_tdata
);

  logic       skid_valid;
  bfr_range_t skid_data;
  logic       drain;

  assign drain = m_tvalid & m_tready;
  assign room  = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // No new results arrive while the skid stage is full.
      if (drain) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!m_tvalid || drain) begin
      m_tvalid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (drain) begin
        m_tdata <= skid_data;
      end
    end else if (!m_tvalid || drain) begin
      m_tdata <= res_data;
    end else if (res_valid) begin
      skid_data <= res_data;
    end
  end

endmodule

`default_nettype wire

[hdl/brace_fold_range_finder_unit.sv]
// Brace fold range finder: takes one text byte per transfer and one transfer per
// clock while s_tready is high, and reports (start_line, end_line) for every brace
// block within the stack depth that spans two lines or more, up to max_ranges per
// document. Each accepted byte updates the line, depth and emitted counters and the
// brace stack in that same cycle; a result is registered in the output buffer
// before it shows on m_tvalid. The stack is a chain of STACK_DEPTH cells that all
// shift one place per push or pop, so the top of the stack always sits in the
// first cell and no memory port limits the rate. An output register plus a skid
// stage let s_tready stay high while one result waits; s_tready drops only when two
// results are pending. Stack contents need no clearing after reset or doc_start:
// an entry is read only after a push in the same document wrote it.
// Depends on bfr_pkg, bfr_cell and bfr_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module brace_fold_range_finder_unit
  import bfr_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_WIDTH  = 20
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // stream in
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,   // [7:0] char_code
  input  wire logic [1:0]          s_tuser,   // [0] in_literal, [1] doc_start
  // stream out
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [39:0]              m_tdata,   // [19:0] start_line, [39:20] end_line
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam logic [LINE_WIDTH-1:0] LINE_MAX   = {LINE_WIDTH{1'b1}};
  localparam logic [DEPTH_W-1:0]    STACK_SIZE = DEPTH_W'(STACK_DEPTH);

  // Configuration register
  logic [MAXR_W-1:0] max_ranges;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_MAX_RANGES);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_ranges <= MAXR_RESET;
    end else if (cfg_write) begin
      max_ranges <= pwdata[MAXR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_RANGES) begin
      prdata = {{(APB_DW-MAXR_W){1'b0}}, max_ranges};
    end
  end

  // Input decode
  logic              accept;
  logic [CHAR_W-1:0] char_code;
  logic              in_literal;
  logic              doc_start;
  logic              room;

  assign s_tready   = room;
  assign accept     = s_tvalid & s_tready;
  assign char_code  = s_tdata;
  assign in_literal = s_tuser[0];
  assign doc_start  = s_tuser[1];

  // Counters
  logic [LINE_WIDTH-1:0] line_count, line_next, eff_line;
  logic [DEPTH_W-1:0]    open_depth, depth_next, eff_depth;
  logic [MAXR_W-1:0]     emitted_count, emitted_next, eff_emitted;

  logic [LINE_WIDTH-1:0] stack_q [STACK_DEPTH];
  logic [LINE_WIDTH-1:0] top_line;
  bfr_shift_t            shift;
  logic                  res_valid;
  bfr_range_t            res_data;

  // Zero-extend or truncate a stack/line value to the output field width.
  logic [OUT_W+LINE_WIDTH-1:0] start_ext, end_ext;

  assign top_line = stack_q[0];

  always_comb begin
    // doc_start clears the counters before this byte is processed
    eff_line    = doc_start ? '0 : line_count;
    eff_depth   = doc_start ? '0 : open_depth;
    eff_emitted = doc_start ? '0 : emitted_count;

    line_next    = eff_line;
    depth_next   = eff_depth;
    emitted_next = eff_emitted;
    shift        = '0;
    res_valid    = 1'b0;

    if (char_code == CH_NEWLINE) begin
      // Count every newline, literal or not; hold at the top value.
      if (eff_line != LINE_MAX) begin
        line_next = eff_line + 1'b1;
      end
    end else if (!in_literal) begin
      if (char_code == CH_OPEN) begin
        // Store only while the chain has room; deeper opens are just counted.
        shift.push = (eff_depth < STACK_SIZE);
        if (eff_depth != DEPTH_MAX) begin
          depth_next = eff_depth + 1'b1;
        end
      end else if (char_code == CH_CLOSE && eff_depth != '0) begin
        depth_next = eff_depth - 1'b1;
        // The popped level was stored only if it lies inside the chain.
        shift.pop  = (eff_depth <= STACK_SIZE);
        if (shift.pop && (top_line < eff_line) && (eff_emitted < max_ranges)) begin
          res_valid    = 1'b1;
          emitted_next = eff_emitted + 1'b1;
        end
      end
    end

    if (!accept) begin
      shift     = '0;
      res_valid = 1'b0;
    end
  end

  always_comb begin
    start_ext           = {{OUT_W{1'b0}}, top_line};
    end_ext             = {{OUT_W{1'b0}}, eff_line};
    res_data.start_line = start_ext[OUT_W-1:0];
    res_data.end_line   = end_ext[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= '0;
      open_depth    <= '0;
      emitted_count <= '0;
    end else if (accept) begin
      line_count    <= line_next;
      open_depth    <= depth_next;
      emitted_count <= emitted_next;
    end
  end

  // Stack: chain of cells, top of stack in the first one. A push feeds the
  // current line into the first cell; a pop pulls each entry one place up.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_stack
    logic [LINE_WIDTH-1:0] from_above;
    logic [LINE_WIDTH-1:0] from_below;

    if (i == 0) begin : g_head
      assign from_above = eff_line;
    end else begin : g_link_up
      assign from_above = stack_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_tail
      assign from_below = stack_q[i];
    end else begin : g_link_down
      assign from_below = stack_q[i+1];
    end

    bfr_cell #(
      .LINE_WIDTH (LINE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_above (from_above),
      .from_below (from_below),
      .entry      (stack_q[i])
    );
  end

  // Result buffer: output register plus skid stage.
  bfr_range_t m_range;

  bfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_data  (res_data),
    .room      (room),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_range)
  );

  assign m_tdata = m_range;

endmodule

`default_nettype wire

[hdl/bfr_checker.sv]
// Port-level checks for the brace fold range finder, bound to its top level.
// Depends on bfr_pkg and brace_fold_range_finder_unit.
`timescale 1ns / 1ps
`default_nettype none

module bfr_checker
  import bfr_pkg::*;
#(
  parameter int LINE_WIDTH = 20
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  localparam bit WIDE_LINES = (LINE_WIDTH > OUT_W);

  // Nothing is pending right after reset.
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Input backpressure only while a result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // A reported block always opens before it closes; checked only when lines fit the output field.
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (WIDE_LINES || (m_tdata[19:0] < m_tdata[39:20])))
    else $error("fold range start not before end");

endmodule

bind brace_fold_range_finder_unit bfr_checker #(
  .LINE_WIDTH (LINE_WIDTH)
) u_bfr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/bfr_range_checker.sv]
// Checker for the brace fold range finder: watches both stream channels and the
// register port, predicts each fold range and compares it with what the block sends.
// Depends on bfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfr_range_checker
  import bfr_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_WIDTH  = 20
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] char_code
  input  wire logic [1:0]        s_tuser,   // [0] in_literal, [1] doc_start
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [39:0]       m_tdata,   // [19:0] start_line, [39:20] end_line
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  input  wire logic [APB_DW-1:0] prdata,
  input  wire logic              pready,
  output int                     mismatches,
  output int                     pending_ranges,
  output int                     ranges_checked
);

  localparam int SLOT_W = $clog2(STACK_DEPTH);

  logic [LINE_WIDTH-1:0] line_now;
  logic [DEPTH_W-1:0]    depth_now;
  logic [MAXR_W-1:0]     ranges_out;
  logic [MAXR_W-1:0]     range_limit;
  logic [LINE_WIDTH-1:0] open_line_stack [STACK_DEPTH];
  bfr_range_t            expected_ranges [$];

  // Advance the document state by one byte and queue the fold range it closes.
  task automatic fold_byte(input logic [CHAR_W-1:0] ch, input logic lit, input logic ds);
    logic [LINE_WIDTH-1:0] first;
    bfr_range_t            span;
    if (ds) begin
      line_now   = '0;
      depth_now  = '0;
      ranges_out = '0;
    end
    if (ch == CH_NEWLINE) begin
      if (line_now != '1) line_now = line_now + 1'b1;
    end else if (!lit) begin
      if (ch == CH_OPEN) begin
        if (depth_now < STACK_DEPTH) open_line_stack[depth_now[SLOT_W-1:0]] = line_now;
        if (depth_now != DEPTH_MAX) depth_now = depth_now + 1'b1;
      end else if (ch == CH_CLOSE && depth_now != '0) begin
        depth_now = depth_now - 1'b1;
        // opens beyond the stack were never stored, so their closes stay silent
        if (depth_now < STACK_DEPTH) begin
          first = open_line_stack[depth_now[SLOT_W-1:0]];
          if (first < line_now && ranges_out < range_limit) begin
            span.start_line = OUT_W'(first);
            span.end_line   = OUT_W'(line_now);
            expected_ranges.push_back(span);
            ranges_out = ranges_out + 1'b1;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    bfr_range_t got;
    bfr_range_t want;
    if (rst) begin
      line_now    = '0;
      depth_now   = '0;
      ranges_out  = '0;
      range_limit = MAXR_RESET;
      expected_ranges.delete();
    end else begin
      // compare the result first: it can only belong to an earlier byte
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_ranges.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected range, expected none, actual start %0d end %0d",
                   $time, got.start_line, got.end_line);
        end else begin
          want = expected_ranges.pop_front();
          ranges_checked++;
          if (got.start_line !== want.start_line) begin
            mismatches++;
            $display("%0t: start_line expected %0d, actual %0d",
                     $time, want.start_line, got.start_line);
          end
          if (got.end_line !== want.end_line) begin
            mismatches++;
            $display("%0t: end_line expected %0d, actual %0d",
                     $time, want.end_line, got.end_line);
          end
        end
      end
      if (s_tvalid && s_tready) fold_byte(s_tdata, s_tuser[0], s_tuser[1]);
      if (psel && penable && pready && paddr[2] == REG_MAX_RANGES) begin
        if (pwrite) begin
          range_limit = pwdata[MAXR_W-1:0];
        end else if (prdata[MAXR_W-1:0] !== range_limit) begin
          mismatches++;
          $display("%0t: max_ranges read expected %0d, actual %0d",
                   $time, range_limit, prdata[MAXR_W-1:0]);
        end
      end
    end
    pending_ranges <= expected_ranges.size();
  end

endmodule

`default_nettype wire

[tb/brace_fold_range_finder_unit_tb.sv]
// Top of the brace fold range finder testbench: clock, reset, byte stimulus,
// register writes, receiver back-pressure, watchdog and verdict.
// Depends on bfr_pkg, brace_fold_range_finder_unit and bfr_range_checker.
`timescale 1ns / 1ps
`default_nettype none

module brace_fold_range_finder_unit_tb;
  import bfr_pkg::*;

  localparam int STACK_DEPTH      = 64;
  localparam int LINE_WIDTH       = 20;
  localparam int RESET_CYCLES     = 5;
  localparam int DRAIN_CYCLES     = 4;
  localparam int HOLD_CYCLES      = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT      = 5000;  // cycles without any transfer
  localparam int RANDOM_PER_PHASE = 388;
  localparam logic [MAXR_W-1:0]   MAXR_TOP        = 13'd4096;
  localparam logic [APB_AW-1:0]   MAX_RANGES_ADDR = {REG_MAX_RANGES, 2'b00};

  // shape of a random document: wander, or climb past the stack and come back
  typedef enum logic [1:0] {WANDER, CLIMB, DESCEND} doc_shape_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;   // [7:0] char_code
  logic [1:0]        s_tuser  = '0;   // [0] in_literal, [1] doc_start
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [39:0]       m_tdata;         // [19:0] start_line, [39:20] end_line
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [APB_AW-1:0] paddr    = '0;
  logic [APB_DW-1:0] pwdata   = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int mismatches;
  int pending_ranges;
  int ranges_checked;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  bit hold_req        = 1'b0;
  int bytes_sent      = 0;
  int settings_written = 0;
  int quiet_cycles    = 0;

  brace_fold_range_finder_unit #(
    .STACK_DEPTH(STACK_DEPTH),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bfr_range_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .pending_ranges(pending_ranges),
    .ranges_checked(ranges_checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: stall at random, or hold off for a long stretch when asked.
  // The hold is counted here so the sender keeps pushing bytes meanwhile.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one byte, idling first at random, and hold it until the transfer.
  // tvalid stays high on return so back-to-back bytes never drop it.
  task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic lit, input logic ds);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= {ds, lit};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop tvalid and wait until every predicted range has come back. The wait before
  // the check lets the checker's registered count catch up with the last accepted byte.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_ranges != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write max_ranges, then read it back; psel stays high across both accesses.
  task automatic set_max_ranges(input logic [MAXR_W-1:0] limit);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= MAX_RANGES_ADDR;
    pwdata  <= APB_DW'(limit);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_written++;
  endtask

  // Random documents: mostly braces and newlines with random bytes and literal
  // flags mixed in; now and then a document nests past the stack and unwinds.
  task automatic random_text(input int count);
    int          depth_guess;
    int          pick;
    int          open_pct;
    int          close_pct;
    doc_shape_t  shape;
    logic [CHAR_W-1:0] ch;
    logic        lit;
    logic        ds;
    depth_guess = 0;
    shape       = WANDER;
    for (int i = 0; i < count; i++) begin
      // the first byte always opens a document so leftover depth is cleared
      ds = (i == 0) || (shape == WANDER && $urandom_range(99) < 2);
      if (ds) begin
        depth_guess = 0;
        shape = ($urandom_range(11) == 0) ? CLIMB : WANDER;
      end
      if (shape == CLIMB && depth_guess > STACK_DEPTH + 6) shape = DESCEND;
      if (shape == DESCEND && depth_guess == 0) shape = WANDER;
      case (shape)
        CLIMB: begin
          open_pct  = 55;
          close_pct = 5;
        end
        DESCEND: begin
          open_pct  = 5;
          close_pct = 55;
        end
        default: begin
          open_pct  = 22;
          close_pct = 22;
        end
      endcase
      lit  = ($urandom_range(99) < 8);
      pick = $urandom_range(99);
      if (pick < 28) ch = CH_NEWLINE;
      else if (pick < 28 + open_pct) ch = CH_OPEN;
      else if (pick < 28 + open_pct + close_pct) ch = CH_CLOSE;
      else ch = CHAR_W'($urandom_range(255));
      if (!lit) begin
        if (ch == CH_OPEN) depth_guess++;
        else if (ch == CH_CLOSE && depth_guess > 0) depth_guess--;
      end
      send_byte(ch, lit, ds);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed bytes under the reset limit of max_ranges.
    send_byte(8'h00, 1'b0, 1'b1);          // document start on the lowest code
    send_byte(CH_CLOSE, 1'b0, 1'b0);       // close with nothing open: ignore
    send_byte(CH_OPEN, 1'b0, 1'b0);
    send_byte(CH_CLOSE, 1'b0, 1'b0);       // block on one line: no range
    send_byte(CH_OPEN, 1'b0, 1'b0);
    send_byte(CH_NEWLINE, 1'b1, 1'b0);     // newline inside a literal still counts
    send_byte(CH_CLOSE, 1'b1, 1'b0);       // brace inside a literal: ignore
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(CH_OPEN, 1'b1, 1'b0);
    send_byte(CH_CLOSE, 1'b0, 1'b0);       // range 0..1
    send_byte(CH_OPEN, 1'b0, 1'b0);
    send_byte(CH_NEWLINE, 1'b0, 1'b0);
    send_byte(CH_CLOSE, 1'b0, 1'b1);       // document start drops the open brace
    drain();

    // A limit of zero emits nothing.
    set_max_ranges('0);
    send_byte(CH_OPEN, 1'b0, 1'b0);
    send_byte(CH_NEWLINE, 1'b0, 1'b0);
    send_byte(CH_CLOSE, 1'b0, 1'b0);
    drain();

    // A limit of one: the first range passes, the second is cut off.
    set_max_ranges(13'd1);
    send_byte(CH_NEWLINE, 1'b0, 1'b1);
    send_byte(CH_OPEN, 1'b0, 1'b0);
    send_byte(CH_NEWLINE, 1'b0, 1'b0);
    send_byte(CH_CLOSE, 1'b0, 1'b0);
    send_byte(CH_OPEN, 1'b0, 1'b0);
    send_byte(CH_NEWLINE, 1'b0, 1'b0);
    send_byte(CH_CLOSE, 1'b0, 1'b0);
    drain();

    // Random phases: each with its own idle mix and max_ranges setting.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
          set_max_ranges(MAXR_TOP);
        end
        1: begin
          sender_idle_pct = 83;
          recv_stall_pct  = 0;
          set_max_ranges(13'd2);
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 83;
          set_max_ranges(MAXR_W'($urandom_range(4096, 1)));
        end
        default: begin
          sender_idle_pct = 7;
          recv_stall_pct  = 7;
          set_max_ranges(MAXR_RESET);
        end
      endcase
      random_text(RANDOM_PER_PHASE / 2);
      if (phase == 0) begin
        // Pause until every range is back, then hold the receiver while
        // two-line blocks keep coming so the input side has to stall.
        drain();
        hold_req = 1'b1;
        send_byte(CH_NEWLINE, 1'b0, 1'b1);
        repeat (24) begin
          send_byte(CH_OPEN, 1'b0, 1'b0);
          send_byte(CH_NEWLINE, 1'b0, 1'b0);
          send_byte(CH_CLOSE, 1'b0, 1'b0);
        end
      end
      random_text(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
      drain();
    end

    $display("covered %0d text bytes over %0d max_ranges settings, four idle mixes",
             bytes_sent, settings_written);
    $display("compared %0d fold ranges, nesting past the stack and a long hold-off",
             ranges_checked);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/bfr_pkg.sv
hdl/bfr_cell.sv
hdl/bfr_out_buf.sv
hdl/brace_fold_range_finder_unit.sv
hdl/bfr_checker.sv
tb/bfr_range_checker.sv
tb/brace_fold_range_finder_unit_tb.sv
